// ===== rtl/itbd_pkg.sv =====
package itbd_pkg;

  localparam int MAX_BASE_DEF     = 16;
  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int DIGIT_DEPTH_DEF  = 32;

  localparam int IN_W        = 32;
  localparam int CHAR_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int BASE_W      = 5;
  localparam int NUM_SYMBOLS = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]     BASE_LENGTH_RST  = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef logic [NUM_SYMBOLS-1:0][CHAR_W-1:0] sym_table_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic negative;
    logic div_last;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/itbd_num_if.sv =====
interface itbd_num_if import itbd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

// ===== rtl/itbd_char_if.sv =====
interface itbd_char_if import itbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

// ===== rtl/itbd_cfg_if.sv =====
interface itbd_cfg_if import itbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/integer_to_base_digits.sv =====
// Converts each signed number request into its text in a configurable radix of 2 to 16
// symbols, one character per output request, most significant digit first, with a leading
// '-' for negative numbers and last_char set on the final character; a base that is too
// short, too long, repeats a symbol or uses '+' or '-' gives no output. A request is taken
// only while no earlier number is being worked on, but the final character may still wait
// in the output register. A taken number is loaded and the base checked; then, for each
// digit, the divider works through the magnitude byte by byte from its highest non-zero
// byte down (the divider retires 8 quotient bits per cycle); then the sign and the digits
// go out one character per output request. With an invalid base the number is dropped
// after the check. There is no clearing pass after reset.
module integer_to_base_digits import itbd_pkg::*; #(
  parameter int MAX_BASE     = MAX_BASE_DEF,
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int DIGIT_DEPTH  = DIGIT_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  itbd_cfg_if.sink   cfg,
  itbd_num_if.sink   numbers,
  itbd_char_if.source chars
);

  logic [BASE_W-1:0] base_length;
  sym_table_t        symbols;
  logic              base_ok;
  logic              in_ready;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign numbers.ready = in_ready;

  itbd_cfg_regs #(
    .MAX_BASE(MAX_BASE)
  ) u_cfg_regs (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .base_length(base_length),
    .symbols    (symbols),
    .base_ok    (base_ok)
  );

  itbd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(numbers.valid),
    .in_ready(in_ready),
    .base_ok (base_ok),
    .status  (status),
    .cmd     (cmd)
  );

  itbd_datapath #(
    .NUMBER_WIDTH(NUMBER_WIDTH),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .number     (numbers.number),
    .cmd        (cmd),
    .status     (status),
    .base_length(base_length),
    .symbols    (symbols),
    .chars      (chars)
  );

endmodule

// ===== rtl/itbd_cfg_regs.sv =====
module itbd_cfg_regs import itbd_pkg::*; #(
  parameter int MAX_BASE = MAX_BASE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  itbd_cfg_if.sink          cfg,
  output logic [BASE_W-1:0] base_length,
  output sym_table_t        symbols,
  output logic              base_ok
);

  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;
  logic                  base_ok_next;

  assign cfg.ready = 1'b1;
  assign symbols   = {symbols_high, symbols_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= BASE_LENGTH_RST;
      symbols_low  <= SYMBOLS_LOW_RST;
      symbols_high <= SYMBOLS_HIGH_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BASE_LENGTH:  base_length  <= cfg.data[BASE_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg.data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // length range, no sign symbols, all symbols in use distinct
  always_comb begin
    base_ok_next = (base_length >= BASE_W'(2)) && (base_length <= BASE_W'(MAX_BASE));
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (BASE_W'(i) < base_length) begin
        if (symbols[i] == CHAR_PLUS || symbols[i] == CHAR_MINUS) begin
          base_ok_next = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
          if (BASE_W'(j) < base_length && symbols[i] == symbols[j]) begin
            base_ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ok <= 1'b1;
    end else begin
      base_ok <= base_ok_next;
    end
  end

endmodule

// ===== rtl/itbd_datapath.sv =====
module itbd_datapath import itbd_pkg::*; #(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
  parameter int DIGIT_DEPTH  = DIGIT_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   number,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [BASE_W-1:0] base_length,
  input  sym_table_t        symbols,
  itbd_char_if.source       chars
);

  localparam int CHUNKS = (NUMBER_WIDTH + 7) / 8;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int MAG_W  = CHUNKS * 8;
  localparam int IDX_W  = $clog2(DIGIT_DEPTH);
  localparam int CNT_W  = $clog2(DIGIT_DEPTH + 1);

  logic [CHUNKS-1:0][7:0]   magnitude;
  logic                     negative;
  logic [DIGIT_W-1:0]       remainder;
  logic [CH_W-1:0]          chunk;
  logic [DIGIT_W-1:0]       digit_store [DIGIT_DEPTH];
  logic [CNT_W-1:0]         digit_count;
  logic [CNT_W-1:0]         rd_ptr;
  logic                     out_valid;
  logic [CHAR_W-1:0]        character;
  logic                     last_char;

  logic [NUMBER_WIDTH-1:0]  value;
  logic [NUMBER_WIDTH-1:0]  abs_value;
  logic [7:0]               quot;
  logic [DIGIT_W-1:0]       rem_step;
  logic [CHUNKS-1:0][7:0]   mag_step;
  logic                     digit_end;
  logic [CNT_W-1:0]         rd_dec;
  logic [IDX_W-1:0]         rd_idx;
  logic [DIGIT_W-1:0]       rd_digit;

  function automatic logic [CH_W-1:0] top_chunk(input logic [CHUNKS-1:0][7:0] m);
    logic [CH_W-1:0] res;
    res = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (m[c] != 8'd0) begin
        res = CH_W'(c);
      end
    end
    return res;
  endfunction

  assign value     = number[NUMBER_WIDTH-1:0];
  assign abs_value = value[NUMBER_WIDTH-1] ? (~value + 1'b1) : value;

  // one byte of restoring division per cycle
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r    = remainder;
    quot = '0;
    for (int k = 7; k >= 0; k--) begin
      t = {r, magnitude[chunk][k]};
      if (t >= base_length) begin
        t       = t - base_length;
        quot[k] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_step = r;
    mag_step = magnitude;
    mag_step[chunk] = quot;
  end

  assign digit_end = (chunk == '0);
  assign rd_dec    = rd_ptr - CNT_W'(1);
  assign rd_idx    = rd_dec[IDX_W-1:0];
  assign rd_digit  = digit_store[rd_idx];

  assign status.negative  = negative;
  assign status.div_last  = digit_end &&
                            ((mag_step == '0) || (digit_count == CNT_W'(DIGIT_DEPTH - 1)));
  assign status.emit_last = (rd_ptr == CNT_W'(1));
  assign status.out_free  = !out_valid || chars.ready;

  assign chars.valid     = out_valid;
  assign chars.character = character;
  assign chars.last_char = last_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      rd_ptr      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.div_init) begin
        digit_count <= '0;
      end else if (cmd.div_step && digit_end) begin
        digit_count <= digit_count + CNT_W'(1);
        rd_ptr      <= digit_count + CNT_W'(1);
      end
      if (cmd.emit_digit) begin
        rd_ptr <= rd_dec;
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      magnitude <= MAG_W'(abs_value);
      negative  <= value[NUMBER_WIDTH-1];
    end
    if (cmd.div_init) begin
      remainder <= '0;
      chunk     <= top_chunk(magnitude);
    end
    if (cmd.div_step) begin
      magnitude <= mag_step;
      if (digit_end) begin
        digit_store[digit_count[IDX_W-1:0]] <= rem_step;
        remainder <= '0;
        chunk     <= top_chunk(mag_step);
      end else begin
        remainder <= rem_step;
        chunk     <= chunk - CH_W'(1);
      end
    end
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= symbols[rd_digit];
      last_char <= status.emit_last;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(DIGIT_DEPTH))
    else $error("digit count beyond store depth");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |-> rd_ptr != '0)
    else $error("digit emitted with no digit left");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |=> out_valid && last_char == (rd_ptr == '0))
    else $error("last flag out of step with read pointer");
`endif

endmodule

// ===== rtl/itbd_ctrl.sv =====
module itbd_ctrl import itbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       base_ok,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (base_ok) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIVIDE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = status.negative ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
    else $error("output register overwritten");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ST_IDLE)
    else $error("request taken while busy");
`endif

endmodule
